// File: sv/assert_macros.svh
// Assertion helper macros shared by the date arithmetic RTL.
// No dependencies; include from any module that asserts on clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`endif

// File: sv/dgda_pkg.sv
// Shared constants, types and calendar helper functions for the date arithmetic block.
// No dependencies; imported by the front, queue, back and top level modules.
package dgda_pkg;

   localparam int MAX_YEAR    = 9999;
   localparam int DN_W        = 25;   // signed day number of an input date
   localparam int SUM_W       = 27;   // signed day number plus offset
   localparam int T_W         = 26;   // zero-based day count of the sum
   localparam int YEAR_W      = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [SUM_W-1:0] LAST_DAY =
      SUM_W'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

   // 400-year cycle split by reciprocal multiply
   localparam int Q400_W = 9;
   localparam int R400_W = 18;
   localparam int SH400  = 35;
   localparam logic [R400_W-1:0] R400 = 18'd235184;
   localparam int DAYS_400 = 146097;
   localparam int DAYS_100 = 36524;
   localparam int DAYS_4   = 1461;
   localparam int DAYS_1   = 365;
   localparam int SH4      = 26;
   localparam logic [15:0] R4 = 16'd45934;

   typedef struct packed {
      logic [T_W-1:0] t0;
      logic           oor;
      logic [22:0]    diff;
      logic           lt;
      logic           gt;
      logic           eq;
      logic           valid;
   } dgda_item_type;

   function automatic logic [7:0] div100(input logic [13:0] v);
      logic [26:0] prod;
      prod = 27'(v) * 27'd5243;
      return prod[26:19];
   endfunction

   // days before the first of month m in a common year; months past 12 count the whole year
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] r;
      case (m) inside
         4'd0, 4'd1: r = 9'd0;
         4'd2:       r = 9'd31;
         4'd3:       r = 9'd59;
         4'd4:       r = 9'd90;
         4'd5:       r = 9'd120;
         4'd6:       r = 9'd151;
         4'd7:       r = 9'd181;
         4'd8:       r = 9'd212;
         4'd9:       r = 9'd243;
         4'd10:      r = 9'd273;
         4'd11:      r = 9'd304;
         4'd12:      r = 9'd334;
         default:    r = 9'd365;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
         4'd2:                                      r = leap ? 5'd29 : 5'd28;
         default:                                   r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/dgda_front.sv
// Front end: takes request words, forms day numbers of both dates, the difference,
// the comparisons and the shifted day count. Depends on dgda_pkg.
module dgda_front
   import dgda_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [4:0]          req_a_day,
   input  logic [3:0]          req_a_month,
   input  logic [13:0]         req_a_year,
   input  logic [4:0]          req_b_day,
   input  logic [3:0]          req_b_month,
   input  logic [13:0]         req_b_year,
   input  logic signed [22:0]  req_offset_days,
   output logic                out_valid,
   input  logic                out_ready,
   output dgda_item_type       out_item
);

   typedef struct packed {
      logic [4:0]  d;
      logic [3:0]  m;
      logic [13:0] y;
      logic [13:0] p;
      logic [7:0]  qp;
      logic [7:0]  qy;
   } date_pre_type;

   typedef struct packed {
      logic [DN_W-1:0] dn;
      logic            valid;
   } date_num_type;

   function automatic date_pre_type pre_date(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y);
      date_pre_type r;
      r.d  = d;
      r.m  = m;
      r.y  = y;
      r.p  = y - 14'd1;
      r.qp = div100(r.p);
      r.qy = div100(y);
      return r;
   endfunction

   function automatic date_num_type day_num(input date_pre_type x);
      logic            leap;
      logic [DN_W-1:0] base;
      logic [4:0]      mlen;
      date_num_type    r;
      // year is a multiple of 100 exactly when y/100 and (y-1)/100 differ
      leap = (x.y == 14'd0) ||
             (x.y[1:0] == 2'd0 && (x.qy == x.qp || x.qy[1:0] == 2'd0));
      if (x.y == 14'd0) begin
         base = DN_W'(0) - DN_W'(365);
      end else begin
         base = DN_W'(x.p) * DN_W'(365) + DN_W'(x.p[13:2]) - DN_W'(x.qp)
              + DN_W'(x.qp[7:2]);
      end
      r.dn = base + DN_W'(month_start(x.m)) + DN_W'(leap && x.m >= 4'd3) + DN_W'(x.d);
      mlen = month_len(x.m, leap);
      r.valid = (x.y != 14'd0) && (x.m >= 4'd1) && (x.m <= 4'd12) &&
                (x.d >= 5'd1) && (x.d <= mlen);
      return r;
   endfunction

   logic               s1_v_ff;
   date_pre_type       s1_a_ff, s1_b_ff;
   logic [22:0]        s1_off_ff;
   logic               s2_v_ff;
   date_num_type       s2_a_ff, s2_b_ff;
   logic [22:0]        s2_off_ff;
   logic               s1_ready, s2_ready;
   logic [SUM_W-1:0]   sum;
   logic [DN_W-1:0]    diff_full;

   assign s2_ready  = !s2_v_ff || out_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= req_valid;
      end
      if (s1_ready) begin
         s1_a_ff   <= pre_date(req_a_day, req_a_month, req_a_year);
         s1_b_ff   <= pre_date(req_b_day, req_b_month, req_b_year);
         s1_off_ff <= req_offset_days;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_ready) begin
         s2_a_ff   <= day_num(s1_a_ff);
         s2_b_ff   <= day_num(s1_b_ff);
         s2_off_ff <= s1_off_ff;
      end
   end

   always_comb begin
      sum = {{(SUM_W-DN_W){s2_a_ff.dn[DN_W-1]}}, s2_a_ff.dn}
          + {{(SUM_W-23){s2_off_ff[22]}}, s2_off_ff};
      diff_full      = s2_a_ff.dn - s2_b_ff.dn;
      out_item.t0    = sum[T_W-1:0] - T_W'(1);
      out_item.oor   = ($signed(sum) < $signed(SUM_W'(1))) ||
                       ($signed(sum) > $signed(LAST_DAY));
      out_item.diff  = diff_full[22:0];
      out_item.lt    = $signed(s2_a_ff.dn) < $signed(s2_b_ff.dn);
      out_item.gt    = $signed(s2_a_ff.dn) > $signed(s2_b_ff.dn);
      out_item.eq    = s2_a_ff.dn == s2_b_ff.dn;
      out_item.valid = s2_a_ff.valid;
   end

   assign out_valid = s2_v_ff;

endmodule

// File: sv/dgda_queue.sv
// Short word queue between the front and back ends; each side stalls on its own.
// Depends on dgda_pkg for the word type and depth.
module dgda_queue
   import dgda_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  dgda_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output dgda_item_type out_item
);

   dgda_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              push, pop;

   assign in_ready  = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= in_item;
   end

endmodule

// File: sv/dgda_back.sv
// Back end: turns the shifted day count into a date by 400/100/4/1-year cycles
// and a month search, then holds the response word. Depends on dgda_pkg.
module dgda_back
   import dgda_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dgda_item_type       in_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_sum_day,
   output logic [3:0]          rsp_sum_month,
   output logic [13:0]         rsp_sum_year,
   output logic                rsp_out_of_range,
   output logic signed [22:0]  rsp_day_difference,
   output logic                rsp_a_before_b,
   output logic                rsp_a_after_b,
   output logic                rsp_a_same_as_b,
   output logic                rsp_a_is_valid
);

   localparam int P1_W = T_W + R400_W;

   logic b1_v_ff, b2_v_ff, b3_v_ff, b4_v_ff, b5_v_ff, b6_v_ff, out_v_ff;
   logic b1_rdy, b2_rdy, b3_rdy, b4_rdy, b5_rdy, b6_rdy, out_rdy;
   dgda_item_type b1_item_ff, b2_item_ff, b3_item_ff, b4_item_ff, b5_item_ff, b6_item_ff;

   logic [Q400_W-1:0] b1_q_ff, b2_q_ff, b3_q_ff, b4_q_ff, b5_q_ff;
   logic [18:0]       b2_rem_ff;
   logic [1:0]        b3_c100_ff, b4_c100_ff, b5_c100_ff;
   logic [15:0]       b3_r100_ff, b4_r100_ff;
   logic [4:0]        b4_c4_ff, b5_c4_ff;
   logic [10:0]       b5_r4_ff;
   logic [YEAR_W-1:0] b6_year_ff;
   logic [8:0]        b6_doy_ff;
   logic              b6_leap_ff;

   logic [P1_W-1:0]   prod1;
   logic [T_W-1:0]    rem_full;
   logic [Q400_W-1:0] q_fix;
   logic [17:0]       r_fix;
   logic [1:0]        c100;
   logic [17:0]       r100_full;
   logic [31:0]       prod4;
   logic [15:0]       r4_full;
   logic [1:0]        c1;
   logic [10:0]       r1;
   logic [YEAR_W-1:0] year;
   logic [3:0]        month;
   logic [8:0]        mstart;
   logic [8:0]        day_full;

   assign out_rdy  = !out_v_ff || rsp_ready;
   assign b6_rdy   = !b6_v_ff || out_rdy;
   assign b5_rdy   = !b5_v_ff || b6_rdy;
   assign b4_rdy   = !b4_v_ff || b5_rdy;
   assign b3_rdy   = !b3_v_ff || b4_rdy;
   assign b2_rdy   = !b2_v_ff || b3_rdy;
   assign b1_rdy   = !b1_v_ff || b2_rdy;
   assign in_ready = b1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         b3_v_ff  <= 1'b0;
         b4_v_ff  <= 1'b0;
         b5_v_ff  <= 1'b0;
         b6_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (b1_rdy)  b1_v_ff  <= in_valid;
         if (b2_rdy)  b2_v_ff  <= b1_v_ff;
         if (b3_rdy)  b3_v_ff  <= b2_v_ff;
         if (b4_rdy)  b4_v_ff  <= b3_v_ff;
         if (b5_rdy)  b5_v_ff  <= b4_v_ff;
         if (b6_rdy)  b6_v_ff  <= b5_v_ff;
         if (out_rdy) out_v_ff <= b6_v_ff;
      end
   end

   // estimate the 400-year count low by at most one
   assign prod1 = P1_W'(in_item.t0) * P1_W'(R400);

   always_ff @(posedge clock) begin
      if (b1_rdy) begin
         b1_item_ff <= in_item;
         b1_q_ff    <= prod1[SH400+Q400_W-1:SH400];
      end
   end

   assign rem_full = b1_item_ff.t0 - T_W'(b1_q_ff) * T_W'(DAYS_400);

   always_ff @(posedge clock) begin
      if (b2_rdy) begin
         b2_item_ff <= b1_item_ff;
         b2_q_ff    <= b1_q_ff;
         b2_rem_ff  <= rem_full[18:0];
      end
   end

   always_comb begin
      if (b2_rem_ff >= 19'(DAYS_400)) begin
         q_fix = b2_q_ff + Q400_W'(1);
         r_fix = 18'(b2_rem_ff - 19'(DAYS_400));
      end else begin
         q_fix = b2_q_ff;
         r_fix = b2_rem_ff[17:0];
      end
      // the last day of a 400-year cycle stays in the fourth century
      if (r_fix >= 18'(3 * DAYS_100))      c100 = 2'd3;
      else if (r_fix >= 18'(2 * DAYS_100)) c100 = 2'd2;
      else if (r_fix >= 18'(DAYS_100))     c100 = 2'd1;
      else                                 c100 = 2'd0;
      r100_full = r_fix - 18'(c100) * 18'(DAYS_100);
   end

   always_ff @(posedge clock) begin
      if (b3_rdy) begin
         b3_item_ff <= b2_item_ff;
         b3_q_ff    <= q_fix;
         b3_c100_ff <= c100;
         b3_r100_ff <= r100_full[15:0];
      end
   end

   assign prod4 = 32'(b3_r100_ff) * 32'(R4);

   always_ff @(posedge clock) begin
      if (b4_rdy) begin
         b4_item_ff <= b3_item_ff;
         b4_q_ff    <= b3_q_ff;
         b4_c100_ff <= b3_c100_ff;
         b4_r100_ff <= b3_r100_ff;
         b4_c4_ff   <= prod4[SH4+4:SH4];
      end
   end

   assign r4_full = b4_r100_ff - 16'(b4_c4_ff) * 16'(DAYS_4);

   always_ff @(posedge clock) begin
      if (b5_rdy) begin
         b5_item_ff <= b4_item_ff;
         b5_q_ff    <= b4_q_ff;
         b5_c100_ff <= b4_c100_ff;
         b5_c4_ff   <= b4_c4_ff;
         b5_r4_ff   <= r4_full[10:0];
      end
   end

   always_comb begin
      // the last day of a 4-year cycle stays in its fourth year
      if (b5_r4_ff >= 11'(3 * DAYS_1))      c1 = 2'd3;
      else if (b5_r4_ff >= 11'(2 * DAYS_1)) c1 = 2'd2;
      else if (b5_r4_ff >= 11'(DAYS_1))     c1 = 2'd1;
      else                                  c1 = 2'd0;
      r1   = b5_r4_ff - 11'(c1) * 11'(DAYS_1);
      year = YEAR_W'(b5_q_ff) * YEAR_W'(400) + YEAR_W'(b5_c100_ff) * YEAR_W'(100)
           + YEAR_W'(b5_c4_ff) * YEAR_W'(4) + YEAR_W'(c1) + YEAR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (b6_rdy) begin
         b6_item_ff <= b5_item_ff;
         b6_year_ff <= year;
         b6_doy_ff  <= r1[8:0] + 9'd1;
         b6_leap_ff <= (c1 == 2'd3) && (b5_c4_ff != 5'd24 || b5_c100_ff == 2'd3);
      end
   end

   // month search: later months win, all compares independent
   always_comb begin
      month  = 4'd1;
      mstart = 9'd0;
      for (int k = 2; k <= 12; k++) begin
         if (b6_doy_ff > month_start(4'(k)) + 9'(b6_leap_ff && k >= 3)) begin
            month  = 4'(k);
            mstart = month_start(4'(k)) + 9'(b6_leap_ff && k >= 3);
         end
      end
      day_full = b6_doy_ff - mstart;
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_out_of_range   <= b6_item_ff.oor;
         rsp_sum_day        <= b6_item_ff.oor ? 5'd0 : day_full[4:0];
         rsp_sum_month      <= b6_item_ff.oor ? 4'd0 : month;
         rsp_sum_year       <= b6_item_ff.oor ? 14'd0 : b6_year_ff[13:0];
         rsp_day_difference <= b6_item_ff.diff;
         rsp_a_before_b     <= b6_item_ff.lt;
         rsp_a_after_b      <= b6_item_ff.gt;
         rsp_a_same_as_b    <= b6_item_ff.eq;
         rsp_a_is_valid     <= b6_item_ff.valid;
      end
   end

   assign rsp_valid = out_v_ff;

endmodule

// File: sv/gregorian_date_day_arithmetic.sv
// Proleptic Gregorian day arithmetic: takes one request word per cycle, while
// req_ready is high, and returns A plus an offset as a date, A minus B in days,
// their ordering and A's validity. Throughput is one word per cycle when the response
// side does not stall. A word passes 10 registers (2 front stages forming day numbers,
// one slot of the 4-word queue, 7 back stages splitting the sum into 400/100/4/1-year
// cycles and months) on its way to the response, and waits while the response side stalls.
// Depends on dgda_pkg, dgda_front, dgda_queue, dgda_back.
`include "assert_macros.svh"
module gregorian_date_day_arithmetic
   import dgda_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [4:0]          req_a_day,
   input  logic [3:0]          req_a_month,
   input  logic [13:0]         req_a_year,
   input  logic [4:0]          req_b_day,
   input  logic [3:0]          req_b_month,
   input  logic [13:0]         req_b_year,
   input  logic signed [22:0]  req_offset_days,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_sum_day,
   output logic [3:0]          rsp_sum_month,
   output logic [13:0]         rsp_sum_year,
   output logic                rsp_out_of_range,
   output logic signed [22:0]  rsp_day_difference,
   output logic                rsp_a_before_b,
   output logic                rsp_a_after_b,
   output logic                rsp_a_same_as_b,
   output logic                rsp_a_is_valid
);

   logic          front_valid, front_ready;
   dgda_item_type front_item;
   logic          queue_valid, queue_ready;
   dgda_item_type queue_item;

   dgda_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_a_day       (req_a_day),
      .req_a_month     (req_a_month),
      .req_a_year      (req_a_year),
      .req_b_day       (req_b_day),
      .req_b_month     (req_b_month),
      .req_b_year      (req_b_year),
      .req_offset_days (req_offset_days),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_item        (front_item)
   );

   dgda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   dgda_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (queue_valid),
      .in_ready           (queue_ready),
      .in_item            (queue_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sum_day        (rsp_sum_day),
      .rsp_sum_month      (rsp_sum_month),
      .rsp_sum_year       (rsp_sum_year),
      .rsp_out_of_range   (rsp_out_of_range),
      .rsp_day_difference (rsp_day_difference),
      .rsp_a_before_b     (rsp_a_before_b),
      .rsp_a_after_b      (rsp_a_after_b),
      .rsp_a_same_as_b    (rsp_a_same_as_b),
      .rsp_a_is_valid     (rsp_a_is_valid)
   );

   `ASSERT_CLK(a_order_onehot, rsp_valid |-> $onehot({rsp_a_before_b, rsp_a_after_b, rsp_a_same_as_b}), "ordering flags not one-hot")
   `ASSERT_CLK(a_oor_zero, (rsp_valid && rsp_out_of_range) |-> (rsp_sum_day == 5'd0 && rsp_sum_month == 4'd0 && rsp_sum_year == 14'd0), "out-of-range date not zero")
   `ASSERT_CLK(a_sum_date_ok, (rsp_valid && !rsp_out_of_range) |-> (rsp_sum_month >= 4'd1 && rsp_sum_month <= 4'd12 && rsp_sum_day >= 5'd1), "shifted date malformed")
   `ASSERT_CLK(a_same_zero_diff, (rsp_valid && rsp_a_same_as_b) |-> (rsp_day_difference == 23'sd0), "equal dates with nonzero difference")

endmodule
